// ----- hw/rtl/sbi_pkg.sv -----
// Shared types for the stored-block inflater: result kinds, error codes
// and the action entry passed from the parser to the result emitter.
// No dependencies.
package sbi_pkg;

  // Kind of one result item
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Error codes carried by an error result
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TRUNC    = 3'd1,
    ERR_LENCHK   = 3'd2,
    ERR_HUFF     = 3'd3,
    ERR_RESERVED = 3'd4
  } err_e;

  // Queue depth between parser and emitter
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrBits    = $clog2(QueueDepth);
  localparam int unsigned CntBits    = $clog2(QueueDepth + 1);

  // Reported byte count width
  localparam int unsigned ReportBits = 32;

  // One parsed item: an optional data byte, then an optional done/error result
  typedef struct packed {
    logic                  data_vld;
    logic [7:0]            data;
    logic                  tail_vld;
    kind_e                 tail_kind;
    err_e                  err;
    logic [ReportBits-1:0] count;
  } entry_t;

endpackage

// ----- hw/rtl/sbi_front.sv -----
// Stream parser: accepts compressed bytes, tracks header, length and data
// phases, and pushes one action entry per byte that causes results.
// Depends on sbi_pkg.
module sbi_front #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [7:0]     in_byte_i,
  input  logic           end_of_stream_i,
  input  logic           q_full_i,
  output logic           push_o,
  output sbi_pkg::entry_t entry_o
);

  typedef enum logic [3:0] {
    PH_HDR0, PH_HDR1, PH_DICT, PH_BLOCK, PH_LEN0,
    PH_LEN1, PH_NLEN0, PH_NLEN1, PH_DATA, PH_HALT
  } phase_e;

  localparam logic [1:0] TypeStored  = 2'd0;
  localparam logic [1:0] TypeFixed   = 2'd1;
  localparam logic [1:0] TypeDynamic = 2'd2;
  localparam int unsigned DictFlagBit = 5;
  localparam logic [2:0] DictBytes   = 3'd4;

  phase_e                phase_q, phase_d;
  logic                  final_q, final_d;
  logic [15:0]           len_q, len_d;
  logic [7:0]            nlen_lo_q, nlen_lo_d;
  logic [15:0]           left_q, left_d;
  logic [2:0]            hdr_left_q, hdr_left_d;
  logic [COUNT_BITS-1:0] total_q, total_d;

  logic                  accept;
  logic                  done;
  sbi_pkg::err_e         err;
  logic [1:0]            btype;
  logic [63:0]           total_wide;
  sbi_pkg::entry_t       ent;

  assign accept = in_valid_i && !q_full_i;
  assign btype  = in_byte_i[2:1];

  // Advance the parser by one byte
  always_comb begin
    phase_d    = phase_q;
    final_d    = final_q;
    len_d      = len_q;
    nlen_lo_d  = nlen_lo_q;
    left_d     = left_q;
    hdr_left_d = hdr_left_q;
    total_d    = total_q;
    done       = 1'b0;
    err        = sbi_pkg::ERR_NONE;
    ent        = '0;
    ent.tail_kind = sbi_pkg::KIND_DATA;
    ent.err       = sbi_pkg::ERR_NONE;

    case (phase_q)
      PH_HDR0: begin
        if (end_of_stream_i) err = sbi_pkg::ERR_TRUNC;
        else phase_d = PH_HDR1;
      end
      PH_HDR1: begin
        if (end_of_stream_i) begin
          err = sbi_pkg::ERR_TRUNC;
        end else if (in_byte_i[DictFlagBit]) begin
          hdr_left_d = DictBytes;
          phase_d    = PH_DICT;
        end else begin
          phase_d = PH_BLOCK;
        end
      end
      PH_DICT: begin
        if (end_of_stream_i) begin
          err = sbi_pkg::ERR_TRUNC;
        end else begin
          hdr_left_d = hdr_left_q - 3'd1;
          if (hdr_left_q == 3'd1) phase_d = PH_BLOCK;
        end
      end
      PH_BLOCK: begin
        final_d = in_byte_i[0];
        if (btype inside {TypeFixed, TypeDynamic}) err = sbi_pkg::ERR_HUFF;
        else if (btype != TypeStored) err = sbi_pkg::ERR_RESERVED;
        else if (end_of_stream_i) err = sbi_pkg::ERR_TRUNC;
        else phase_d = PH_LEN0;
      end
      PH_LEN0: begin
        len_d = {8'h00, in_byte_i};
        if (end_of_stream_i) err = sbi_pkg::ERR_TRUNC;
        else phase_d = PH_LEN1;
      end
      PH_LEN1: begin
        len_d = {in_byte_i, len_q[7:0]};
        if (end_of_stream_i) err = sbi_pkg::ERR_TRUNC;
        else phase_d = PH_NLEN0;
      end
      PH_NLEN0: begin
        nlen_lo_d = in_byte_i;
        if (end_of_stream_i) err = sbi_pkg::ERR_TRUNC;
        else phase_d = PH_NLEN1;
      end
      PH_NLEN1: begin
        if ((len_q ^ {in_byte_i, nlen_lo_q}) != 16'hFFFF) begin
          err = sbi_pkg::ERR_LENCHK;
        end else if (end_of_stream_i) begin
          err = sbi_pkg::ERR_TRUNC;
        end else if (len_q == 16'd0) begin
          if (final_q) begin
            done    = 1'b1;
            phase_d = PH_HALT;
          end else begin
            phase_d = PH_BLOCK;
          end
        end else begin
          left_d  = len_q;
          phase_d = PH_DATA;
        end
      end
      PH_DATA: begin
        if (end_of_stream_i) begin
          err = sbi_pkg::ERR_TRUNC;
        end else begin
          ent.data_vld = 1'b1;
          ent.data     = in_byte_i;
          if (total_q != '1) total_d = total_q + COUNT_BITS'(1);
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            if (final_q) begin
              done    = 1'b1;
              phase_d = PH_HALT;
            end else begin
              phase_d = PH_BLOCK;
            end
          end
        end
      end
      default: begin
        // drop bytes after success or error
      end
    endcase

    // Saturate the running total into the reported width
    total_wide = 64'(total_d);

    if (err != sbi_pkg::ERR_NONE) begin
      ent.tail_vld  = 1'b1;
      ent.tail_kind = sbi_pkg::KIND_ERROR;
      ent.err       = err;
      phase_d       = PH_HALT;
    end else if (done) begin
      ent.tail_vld  = 1'b1;
      ent.tail_kind = sbi_pkg::KIND_DONE;
      ent.count     = (|total_wide[63:32]) ? '1 : total_wide[31:0];
    end

    // Rearm for a new stream after its last byte
    if (end_of_stream_i) begin
      phase_d    = PH_HDR0;
      final_d    = 1'b0;
      len_d      = '0;
      nlen_lo_d  = '0;
      left_d     = '0;
      hdr_left_d = '0;
      total_d    = '0;
    end
  end

  assign push_o  = accept && (ent.data_vld || ent.tail_vld);
  assign entry_o = ent;

  // Hold parser state between accepted bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HDR0;
      final_q    <= 1'b0;
      len_q      <= '0;
      nlen_lo_q  <= '0;
      left_q     <= '0;
      hdr_left_q <= '0;
      total_q    <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      final_q    <= final_d;
      len_q      <= len_d;
      nlen_lo_q  <= nlen_lo_d;
      left_q     <= left_d;
      hdr_left_q <= hdr_left_d;
      total_q    <= total_d;
    end
  end

`ifndef ASSERT_OFF
  a_dict_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DICT |-> (hdr_left_q != 3'd0 && hdr_left_q <= DictBytes))
    else $error("dictionary byte count out of range");

  a_data_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> left_q != 16'd0)
    else $error("data phase with no bytes left");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("push into full queue");
`endif

endmodule

// ----- hw/rtl/sbi_queue.sv -----
// Short queue of parsed action entries between parser and emitter.
// Depends on sbi_pkg.
module sbi_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sbi_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sbi_pkg::entry_t head_o
);

  sbi_pkg::entry_t                   mem_q [sbi_pkg::QueueDepth];
  logic [sbi_pkg::PtrBits-1:0]       wr_ptr_q, rd_ptr_q;
  logic [sbi_pkg::CntBits-1:0]       cnt_q;
  logic                              do_push, do_pop;

  assign full_o  = cnt_q == sbi_pkg::CntBits'(sbi_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= entry_i;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + sbi_pkg::PtrBits'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + sbi_pkg::PtrBits'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + sbi_pkg::CntBits'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - sbi_pkg::CntBits'(1);
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= sbi_pkg::CntBits'(sbi_pkg::QueueDepth))
    else $error("queue occupancy exceeds depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0 && cnt_q != sbi_pkg::CntBits'(sbi_pkg::QueueDepth))
      |-> wr_ptr_q != rd_ptr_q)
    else $error("queue pointers disagree with occupancy");
`endif

endmodule

// ----- hw/rtl/sbi_back.sv -----
// Result emitter: turns the head queue entry into one or two result items,
// the data byte first and the done or error result after it.
// Depends on sbi_pkg.
module sbi_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           empty_i,
  input  sbi_pkg::entry_t                head_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     kind_o,
  output logic [7:0]                     data_byte_o,
  output logic [2:0]                     error_code_o,
  output logic [sbi_pkg::ReportBits-1:0] byte_count_o,
  output logic                           last_of_run_o
);

  logic sent_data_q;
  logic show_data;
  logic accept;

  assign show_data   = head_i.data_vld && !sent_data_q;
  assign out_valid_o = !empty_i;
  assign accept      = out_valid_o && !out_stall_i;
  assign pop_o       = accept && last_of_run_o;

  // Select the current result of the head entry
  always_comb begin
    if (show_data) begin
      kind_o        = sbi_pkg::KIND_DATA;
      data_byte_o   = head_i.data;
      error_code_o  = sbi_pkg::ERR_NONE;
      byte_count_o  = '0;
      last_of_run_o = !head_i.tail_vld;
    end else begin
      kind_o        = head_i.tail_kind;
      data_byte_o   = '0;
      error_code_o  = (head_i.tail_kind == sbi_pkg::KIND_ERROR) ? head_i.err
                                                               : sbi_pkg::ERR_NONE;
      byte_count_o  = (head_i.tail_kind == sbi_pkg::KIND_DONE) ? head_i.count : '0;
      last_of_run_o = 1'b1;
    end
  end

  // Mark the data byte sent while its tail result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_data_q <= 1'b0;
    end else if (accept) begin
      sent_data_q <= !last_of_run_o;
    end
  end

`ifndef ASSERT_OFF
  a_sent_has_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sent_data_q |-> (!empty_i && head_i.data_vld && head_i.tail_vld))
    else $error("pending tail result without a two-result entry");
`endif

endmodule

// ----- hw/rtl/stored_block_inflater.sv -----
// Stored-block inflater top level: parser, action queue and result emitter.
// Depends on sbi_pkg, sbi_front, sbi_queue and sbi_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one compressed byte per
//   item with end_of_stream_i marking the last byte of a stream. Output
//   channel (out_valid_o / out_stall_i) gives result items: data bytes,
//   a done result with the byte count, or an error with its code;
//   last_of_run_o flags the last result caused by one input byte.
//   Throughput: one input byte per cycle while in_stall_o is low. A byte
//   that causes results is written to the queue and shows its first
//   result from there; a byte with two results holds the output for both.
//   The parser advances once per accepted byte; the output side drains one
//   result per cycle while out_stall_i is low. A four-entry queue separates
//   the parser from the output, so input keeps flowing while results wait.
//   When the receiver stalls, the queue fills and in_stall_o rises once it
//   is full; bytes that cause no result still need a free slot to be taken.
//   Reset empties the queue and returns the parser to the first header byte
//   of a new stream; the block is ready as soon as reset is released.
module stored_block_inflater #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  error_code_o,
  output logic [31:0] byte_count_o,
  output logic        last_of_run_o
);

  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;
  sbi_pkg::entry_t entry;
  sbi_pkg::entry_t head;

  assign in_stall_o = q_full;

  sbi_front #(
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_byte_i      (in_byte_i),
    .end_of_stream_i(end_of_stream_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .entry_o        (entry)
  );

  sbi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (head)
  );

  sbi_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .kind_o       (kind_o),
    .data_byte_o  (data_byte_o),
    .error_code_o (error_code_o),
    .byte_count_o (byte_count_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule
